### rtl/pvpc_pkg.sv
// Shared types, register codes and constants of the velocity PID controller.
package pvpc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_OUT_UPPER  = 3'd3,
    REG_OUT_LOWER  = 3'd4,
    REG_DEADBAND   = 3'd5,
    REG_DUTY_FLOOR = 3'd6,
    REG_PWM_PERIOD = 3'd7
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_ERR,
    S_EL,
    S_PROD,
    S_ACC,
    S_AMAG,
    S_I_LO,
    S_I_HI,
    S_I_SUM,
    S_I_GO,
    S_I_WAIT,
    S_D_M,
    S_D_LO,
    S_D_HI,
    S_D_SUM,
    S_D_GO,
    S_D_WAIT,
    S_SUM,
    S_CLAMP,
    S_VMUL,
    S_CMP
  } ctrl_state_t;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Quotient bits produced by the divider; a quotient at or above 2^61 saturates
  localparam int QUOT_BITS = 62;

  // Term and sum width, signed
  localparam int TERM_W = 64;
  typedef logic signed [TERM_W-1:0] term_t;

  // Error times elapsed time, signed
  localparam int PROD_W = 52;

  // Derivative numerator width: 32-bit gain magnitude by 52-bit scaled error change
  localparam int D_NUM_W = 84;

  // Microseconds per second
  localparam int MICRO_W = 20;
  localparam logic [MICRO_W-1:0] MICRO = 20'd1000000;

  // Register reset values
  localparam logic signed [31:0] GAIN_PROP_RST  = 32'sd65536;
  localparam logic signed [31:0] OUT_UPPER_RST  = 32'sd65536;
  localparam logic signed [31:0] OUT_LOWER_RST  = -32'sd65536;
  localparam logic [15:0]        DUTY_FLOOR_RST = 16'd32768;
  localparam logic [15:0]        PWM_PERIOD_RST = 16'd1000;

  // Apply a sign to a saturated term magnitude
  function automatic term_t to_term(input logic [QUOT_BITS-1:0] mag, input logic neg);
    term_t m;
    m = term_t'(mag);
    return neg ? -m : m;
  endfunction

endpackage

### rtl/pvpc_mul.sv
// Shared unsigned multiplier with a registered product.
module pvpc_mul import pvpc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  // Capture product only when a step issues an operation
  always_ff @(posedge clk) begin
    if (en) begin
      p <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule

### rtl/pvpc_div.sv
// Iterative restoring divider, two quotient bits per cycle, saturating at 2^61.
module pvpc_div import pvpc_pkg::*; #(
  parameter int NUM_W = 84,
  parameter int DEN_W = 36
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic                 done,
  output logic [QUOT_BITS-1:0] quot
);

  localparam int STEPS = QUOT_BITS / 2;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam logic [QUOT_BITS-1:0] QUOT_CAP = QUOT_BITS'(1) << (QUOT_BITS - 1);

  logic                 run;
  logic [CNT_W-1:0]     cnt;
  logic                 over;
  logic [DEN_W-1:0]     den_q;
  logic [DEN_W-1:0]     rem;
  logic [QUOT_BITS-1:0] qsh;

  logic [DEN_W:0]       r1;
  logic [DEN_W:0]       r2;
  logic                 ge1;
  logic                 ge2;
  logic [DEN_W-1:0]     rem1;
  logic [DEN_W-1:0]     rem2;

  // Two dependent compare-subtract steps
  always_comb begin
    r1   = {rem, qsh[QUOT_BITS-1]};
    ge1  = r1 >= {1'b0, den_q};
    rem1 = ge1 ? DEN_W'(r1 - {1'b0, den_q}) : DEN_W'(r1);
    r2   = {rem1, qsh[QUOT_BITS-2]};
    ge2  = r2 >= {1'b0, den_q};
    rem2 = ge2 ? DEN_W'(r2 - {1'b0, den_q}) : DEN_W'(r2);
  end

  // Control: count iterations and pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      run  <= 1'b1;
      cnt  <= CNT_W'(STEPS);
      done <= 1'b0;
    end else if (run) begin
      cnt  <= cnt - 1'b1;
      run  <= (cnt != CNT_W'(1));
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: load the numerator, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      over  <= (num >> QUOT_BITS) >= NUM_W'(den);
      den_q <= den;
      rem   <= DEN_W'(num >> QUOT_BITS);
      qsh   <= num[QUOT_BITS-1:0];
    end else if (run) begin
      rem   <= rem2;
      qsh   <= {qsh[QUOT_BITS-3:0], ge1, ge2};
    end
  end

  // Saturate the magnitude when the quotient reaches the cap
  assign quot = (over || qsh[QUOT_BITS-1]) ? QUOT_CAP : qsh;

endmodule

### rtl/pid_velocity_pwm_controller.sv
// Each accepted request runs the sequencer from S_ERR to S_CMP; a zero elapsed_us
// skips the derivative states. in_ready is high only in S_IDLE, entered as the result registers.
// Passes of the shared divider (integral and, unless elapsed_us is zero, derivative
// terms) take up most of each request; the shared multiplier serves every product.
// Reset (synchronous, active high) restores the register defaults and clears the
// integral, the previous error, the previous output and the output valid.
module pid_velocity_pwm_controller import pvpc_pkg::*; #(
  parameter int FRAC_BITS     = 16,
  parameter int INTEGRAL_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] target_velocity,
  input  logic signed [31:0] measured_velocity,
  input  logic [19:0]        elapsed_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        compare_value,
  output logic signed [31:0] drive_command,
  output logic signed [31:0] error_value,
  output logic               held,
  output logic               zero_interval
);

  localparam int IB     = INTEGRAL_BITS;
  localparam int SUM_W  = ((IB > PROD_W) ? IB : PROD_W) + 1;
  localparam int I_NUM_W = MUL_B_W + IB;
  localparam int NUM_W  = (I_NUM_W > D_NUM_W) ? I_NUM_W : D_NUM_W;
  localparam int DEN_W  = MICRO_W + FRAC_BITS;
  localparam logic [DEN_W-1:0] MICRO_DEN = DEN_W'(MICRO) << FRAC_BITS;
  localparam logic signed [IB-1:0] ACC_MAX = {1'b0, {(IB - 1){1'b1}}};
  localparam logic signed [IB-1:0] ACC_MIN = {1'b1, {(IB - 1){1'b0}}};
  localparam logic [32:0] ONE_Q = 33'(1) << FRAC_BITS;

  // Configuration registers
  logic signed [31:0] gain_prop;
  logic signed [31:0] gain_integ;
  logic signed [31:0] gain_deriv;
  logic signed [31:0] out_upper;
  logic signed [31:0] out_lower;
  logic [30:0]        deadband;
  logic [15:0]        duty_floor;
  logic [15:0]        pwm_period;

  // Controller state
  logic signed [IB-1:0] acc;
  logic signed [31:0]   last_error;
  logic signed [31:0]   last_output;

  // Working registers
  ctrl_state_t          state;
  ctrl_state_t          state_next;
  logic signed [31:0]   tgt;
  logic signed [31:0]   meas;
  logic [19:0]          el;
  logic signed [31:0]   err;
  logic [31:0]          err_mag;
  logic [32:0]          de_mag;
  logic                 de_neg;
  logic                 hold_flag;
  logic                 zero_flag;
  logic signed [PROD_W-1:0] prod_s;
  logic [63:0]          amag;
  logic [19:0]          mhi;
  logic [NUM_W-1:0]     num;
  term_t                p_term;
  term_t                i_term;
  term_t                d_term;
  term_t                sum;
  logic signed [31:0]   outv;
  logic [31:0]          fp;
  logic                 vpos;

  // Shared unit hookup
  logic                 mul_en;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_q;
  logic                 div_start;
  logic [DEN_W-1:0]     div_den;
  logic                 div_done;
  logic [QUOT_BITS-1:0] div_quot;
  logic                 finish;

  // Combinational helpers
  logic [31:0]          kp_mag;
  logic [31:0]          ki_mag;
  logic [31:0]          kd_mag;
  logic signed [32:0]   diff;
  logic signed [31:0]   err_sat;
  logic signed [32:0]   de;
  logic signed [SUM_W-1:0] acc_sum;
  logic                 acc_ovf;
  logic signed [IB-1:0] acc_next;
  logic [IB-1:0]        acc_abs;
  logic signed [31:0]   clamp_val;
  logic [32:0]          v;
  logic [MUL_P_W-1:0]   cmp_wide;
  logic [15:0]          cmp_val;

  pvpc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_q)
  );

  pvpc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Gain magnitudes
  assign kp_mag = gain_prop[31]  ? 32'(-gain_prop)  : 32'(gain_prop);
  assign ki_mag = gain_integ[31] ? 32'(-gain_integ) : 32'(gain_integ);
  assign kd_mag = gain_deriv[31] ? 32'(-gain_deriv) : 32'(gain_deriv);

  // Error with 32-bit saturation
  always_comb begin
    diff = {tgt[31], tgt} - {meas[31], meas};
    if (diff[32] != diff[31]) begin
      err_sat = diff[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      err_sat = diff[31:0];
    end
  end

  // Change of error since the previous step
  assign de = {err[31], err} - {last_error[31], last_error};

  // Saturating integral update
  always_comb begin
    acc_sum = SUM_W'(acc) + SUM_W'(prod_s);
    acc_ovf = !((&acc_sum[SUM_W-1:IB-1]) || !(|acc_sum[SUM_W-1:IB-1]));
    if (acc_ovf) begin
      acc_next = acc_sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = acc_sum[IB-1:0];
    end
  end

  assign acc_abs = acc[IB-1] ? IB'(-acc) : IB'(acc);

  // Output clamp, upper limit first
  always_comb begin
    if (sum > term_t'(out_upper)) begin
      clamp_val = out_upper;
    end else if (sum < term_t'(out_lower)) begin
      clamp_val = out_lower;
    end else begin
      clamp_val = sum[31:0];
    end
  end

  // Duty offset and compare saturation
  assign v        = {outv[31], outv} + ONE_Q;
  assign cmp_wide = mul_q >> (FRAC_BITS + 16);
  always_comb begin
    if (!vpos) begin
      cmp_val = '0;
    end else if (cmp_wide > MUL_P_W'(pwm_period)) begin
      cmp_val = pwm_period;
    end else begin
      cmp_val = cmp_wide[15:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop  <= GAIN_PROP_RST;
      gain_integ <= '0;
      gain_deriv <= '0;
      out_upper  <= OUT_UPPER_RST;
      out_lower  <= OUT_LOWER_RST;
      deadband   <= '0;
      duty_floor <= DUTY_FLOOR_RST;
      pwm_period <= PWM_PERIOD_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_PROP:  gain_prop  <= cfg_data;
        REG_GAIN_INTEG: gain_integ <= cfg_data;
        REG_GAIN_DERIV: gain_deriv <= cfg_data;
        REG_OUT_UPPER:  out_upper  <= cfg_data;
        REG_OUT_LOWER:  out_lower  <= cfg_data;
        REG_DEADBAND:   deadband   <= cfg_data[30:0];
        REG_DUTY_FLOOR: duty_floor <= cfg_data[15:0];
        REG_PWM_PERIOD: pwm_period <= cfg_data[15:0];
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_ERR;
      S_ERR:    state_next = S_EL;
      S_EL:     state_next = S_PROD;
      S_PROD:   state_next = S_ACC;
      S_ACC:    state_next = S_AMAG;
      S_AMAG:   state_next = S_I_LO;
      S_I_LO:   state_next = S_I_HI;
      S_I_HI:   state_next = S_I_SUM;
      S_I_SUM:  state_next = S_I_GO;
      S_I_GO:   state_next = S_I_WAIT;
      S_I_WAIT: if (div_done) state_next = zero_flag ? S_SUM : S_D_M;
      S_D_M:    state_next = S_D_LO;
      S_D_LO:   state_next = S_D_HI;
      S_D_HI:   state_next = S_D_SUM;
      S_D_SUM:  state_next = S_D_GO;
      S_D_GO:   state_next = S_D_WAIT;
      S_D_WAIT: if (div_done) state_next = S_SUM;
      S_SUM:    state_next = S_CLAMP;
      S_CLAMP:  state_next = S_VMUL;
      S_VMUL:   state_next = S_CMP;
      S_CMP:    if (finish) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: shared unit operands and handshakes
  always_comb begin
    in_ready  = 1'b0;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_den   = MICRO_DEN;
    finish    = 1'b0;
    unique case (state)
      S_IDLE:   in_ready = 1'b1;
      S_EL: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(err_mag);
        mul_b  = MUL_B_W'(el);
      end
      S_PROD: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(err_mag);
        mul_b  = kp_mag;
      end
      S_I_LO: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(amag[31:0]);
        mul_b  = ki_mag;
      end
      S_I_HI: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(amag[63:32]);
        mul_b  = ki_mag;
      end
      S_I_GO:   div_start = 1'b1;
      S_D_M: begin
        mul_en = 1'b1;
        mul_a  = de_mag;
        mul_b  = MUL_B_W'(MICRO);
      end
      S_D_LO: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(mul_q[31:0]);
        mul_b  = kd_mag;
      end
      S_D_HI: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(mhi);
        mul_b  = kd_mag;
      end
      S_D_GO: begin
        div_start = 1'b1;
        div_den   = DEN_W'(el) << FRAC_BITS;
      end
      S_SUM: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(duty_floor);
        mul_b  = MUL_B_W'(pwm_period);
      end
      S_VMUL: begin
        mul_en = 1'b1;
        mul_a  = v;
        mul_b  = fp;
      end
      S_CMP:    finish = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  // Datapath steps
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          tgt  <= target_velocity;
          meas <= measured_velocity;
          el   <= elapsed_us;
        end
      end
      S_ERR: begin
        err     <= err_sat;
        err_mag <= err_sat[31] ? 32'(-err_sat) : 32'(err_sat);
        d_term  <= '0;
      end
      S_EL: begin
        de_mag    <= de[32] ? 33'(-de) : 33'(de);
        de_neg    <= de[32];
        hold_flag <= err_mag <= 32'(deadband);
        zero_flag <= (el == '0);
      end
      S_PROD: begin
        prod_s <= err[31] ? PROD_W'(-mul_q[PROD_W-1:0]) : mul_q[PROD_W-1:0];
      end
      S_ACC: begin
        p_term <= to_term(QUOT_BITS'(mul_q >> FRAC_BITS), gain_prop[31] ^ err[31]);
      end
      S_AMAG:  amag <= 64'(acc_abs);
      S_I_HI:  num <= NUM_W'(mul_q);
      S_I_SUM: num <= num + (NUM_W'(mul_q) << 32);
      S_I_WAIT: begin
        if (div_done) begin
          i_term <= to_term(div_quot, gain_integ[31] ^ acc[IB-1]);
        end
      end
      S_D_LO:  mhi <= mul_q[51:32];
      S_D_HI:  num <= NUM_W'(mul_q);
      S_D_SUM: num <= num + (NUM_W'(mul_q) << 32);
      S_D_WAIT: begin
        if (div_done) begin
          d_term <= to_term(div_quot, gain_deriv[31] ^ de_neg);
        end
      end
      S_SUM:   sum <= p_term + i_term + d_term;
      S_CLAMP: begin
        outv <= hold_flag ? last_output : clamp_val;
        fp   <= mul_q[31:0];
      end
      S_VMUL:  vpos <= !v[32] && (v != '0);
      default: begin
      end
    endcase
  end

  // Controller state: integral advances mid-item, error and output at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      last_error  <= '0;
      last_output <= '0;
    end else begin
      if (state == S_ACC) begin
        acc <= acc_next;
      end
      if (finish) begin
        last_error  <= err;
        last_output <= outv;
      end
    end
  end

  // Result register: hold until the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      compare_value <= cmp_val;
      drive_command <= outv;
      error_value   <= err;
      held          <= hold_flag;
      zero_interval <= zero_flag;
    end
  end

endmodule

### bench/testbench.sv
// Self-checking bench for the velocity PID controller with deadband and PWM mapping.
`timescale 1ns / 1ps

module testbench;
  import pvpc_pkg::*;

  localparam int          FRAC         = 16;
  localparam longint      INTEG_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      INTEG_MIN    = -INTEG_MAX - 1;
  localparam longint      ERR_MAX      = 64'sd2147483647;
  localparam longint      ERR_MIN      = -64'sd2147483648;
  localparam logic [63:0] TERM_CAP     = 64'd1 << 61;
  localparam int          LONG_HOLD    = 600;
  localparam int          DRAIN_CYCLES = 120;
  localparam int          CYCLE_LIMIT  = 1500000;

  typedef struct packed {
    logic signed [31:0] target;
    logic signed [31:0] measured;
    logic [19:0]        elapsed;
  } vel_req_t;

  typedef struct packed {
    logic [15:0]        compare;
    logic signed [31:0] command;
    logic signed [31:0] err_v;
    logic               held;
    logic               zero_int;
  } pwm_res_t;

  typedef logic [31:0] reg_set_t [8];

  typedef enum {TUNE_MODERATE, TUNE_UPPER, TUNE_LOWER, TUNE_WILD, TUNE_HOLD_ALL} tune_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] target_velocity = '0;
  logic signed [31:0] measured_velocity = '0;
  logic [19:0]        elapsed_us = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        compare_value;
  logic signed [31:0] drive_command;
  logic signed [31:0] error_value;
  logic               held;
  logic               zero_interval;

  pid_velocity_pwm_controller dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .target_velocity   (target_velocity),
    .measured_velocity (measured_velocity),
    .elapsed_us        (elapsed_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .compare_value     (compare_value),
    .drive_command     (drive_command),
    .error_value       (error_value),
    .held              (held),
    .zero_interval     (zero_interval)
  );

  // Register mirror
  logic signed [31:0] gain_p  = GAIN_PROP_RST;
  logic signed [31:0] gain_i  = '0;
  logic signed [31:0] gain_d  = '0;
  logic signed [31:0] lim_hi  = OUT_UPPER_RST;
  logic signed [31:0] lim_lo  = OUT_LOWER_RST;
  logic [30:0]        dead_m  = '0;
  logic [15:0]        floor_m = DUTY_FLOOR_RST;
  logic [15:0]        period_m = PWM_PERIOD_RST;

  // Controller state mirror
  logic signed [47:0] integ_acc = '0;
  logic signed [31:0] last_err  = '0;
  logic signed [31:0] last_cmd  = '0;

  vel_req_t    pending_reqs [$];
  pwm_res_t    expected_pwm [$];
  int          reqs_queued = 0;
  int          reqs_sent = 0;
  int          results_seen = 0;
  int          fail_count = 0;
  int          hold_count = 0;
  int          zero_count = 0;
  int          clamp_count = 0;
  int          settings_used = 1;
  int          set_pt = 0;
  int          send_gap = 0;
  int          recv_wait = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  logic        in_taken = 1'b0;
  int unsigned cycle_count = 0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int rand_sign(input int x);
    return $urandom_range(0, 1) ? -x : x;
  endfunction

  // Mostly short gaps, and a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [63:0] magn(input longint a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  // floor(a * b / d), saturated to the term cap
  function automatic logic [63:0] scaled_quot(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] d);
    logic [127:0] q;
    q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
    return (q >= {64'd0, TERM_CAP}) ? TERM_CAP : q[63:0];
  endfunction

  function automatic longint scaled_term(input longint a, input longint b,
                                         input logic [63:0] d);
    logic [63:0] q;
    q = scaled_quot(magn(a), magn(b), d);
    return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // Advance the controller mirror by one request and form its PWM result
  task automatic pid_predict(input vel_req_t rq, output pwm_res_t rs);
    longint      e, prod, acc, p_t, i_t, d_t, total, cmd, v;
    logic [63:0] duty;
    bit          zero, hold;
    zero = (rq.elapsed == '0);
    e = longint'($signed(rq.target)) - longint'($signed(rq.measured));
    if (e > ERR_MAX) e = ERR_MAX;
    else if (e < ERR_MIN) e = ERR_MIN;
    prod = e * longint'(rq.elapsed);
    acc = integ_acc;
    if (prod > 0 && acc > INTEG_MAX - prod) acc = INTEG_MAX;
    else if (prod < 0 && acc < INTEG_MIN - prod) acc = INTEG_MIN;
    else acc = acc + prod;
    integ_acc = acc[47:0];
    p_t = scaled_term(longint'(gain_p), e, 64'd1 << FRAC);
    i_t = scaled_term(longint'(gain_i), acc, 64'd1000000 << FRAC);
    d_t = zero ? 0 : scaled_term(longint'(gain_d), (e - longint'(last_err)) * 1000000,
                                 64'(rq.elapsed) << FRAC);
    total = p_t + i_t + d_t;
    // Upper bound wins when the limits cross
    if (total > longint'(lim_hi)) cmd = longint'(lim_hi);
    else if (total < longint'(lim_lo)) cmd = longint'(lim_lo);
    else cmd = total;
    if (cmd != total) clamp_count++;
    hold = magn(e) <= 64'(dead_m);
    if (hold) cmd = longint'(last_cmd);
    v = cmd + (64'sd1 << FRAC);
    if (v <= 0) duty = '0;
    else duty = scaled_quot(64'(v), 64'(floor_m) * 64'(period_m), 64'd1 << (FRAC + 16));
    if (duty > 64'(period_m)) duty = 64'(period_m);
    last_cmd = cmd[31:0];
    last_err = e[31:0];
    hold_count += int'(hold);
    zero_count += int'(zero);
    rs.compare  = duty[15:0];
    rs.command  = cmd[31:0];
    rs.err_v    = e[31:0];
    rs.held     = hold;
    rs.zero_int = zero;
  endtask

  task automatic add_req(input logic [31:0] t, input logic [31:0] m, input logic [19:0] el);
    pending_reqs.push_back(vel_req_t'({t, m, el}));
    reqs_queued++;
  endtask

  // Mostly a tracking loop near its set point, plus deadband probes, zero intervals and noise
  task automatic add_random_req();
    int          r;
    logic [31:0] t, m, off;
    logic [19:0] el;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 15) == 0) set_pt = rand_sign($urandom_range(0, 60 << 16));
    t = set_pt;
    el = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(1, 20000))
                                     : 20'($urandom_range(900, 1100));
    if (r < 55) begin
      m = t - rand_sign($urandom_range(0, 3 << 16));
    end else if (r < 70) begin
      if (dead_m < 31'h1000_0000 && $urandom_range(0, 2) == 0)
        off = dead_m + $urandom_range(0, 1);
      else
        off = $urandom_range(0, 'h1000);
      m = t - rand_sign(off);
    end else if (r < 80) begin
      m = t - rand_sign($urandom_range(0, 2 << 16));
      el = '0;
    end else if (r < 95) begin
      t = $urandom();
      m = $urandom();
      el = 20'($urandom());
    end else begin
      t = pick_extreme();
      m = pick_extreme();
      case ($urandom_range(0, 2))
        0:       el = '0;
        1:       el = 20'd1;
        default: el = 20'hF_FFFF;
      endcase
    end
    add_req(t, m, el);
  endtask

  // Write all registers, one per cycle, and mirror them
  task automatic load_regs(input reg_set_t v);
    cfg_reg_t idx;
    for (int k = 0; k < 8; k++) begin
      idx = cfg_reg_t'(k);
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= v[k];
      case (idx)
        REG_GAIN_PROP:  gain_p   = v[k];
        REG_GAIN_INTEG: gain_i   = v[k];
        REG_GAIN_DERIV: gain_d   = v[k];
        REG_OUT_UPPER:  lim_hi   = v[k];
        REG_OUT_LOWER:  lim_lo   = v[k];
        REG_DEADBAND:   dead_m   = v[k][30:0];
        REG_DUTY_FLOOR: floor_m  = v[k][15:0];
        REG_PWM_PERIOD: period_m = v[k][15:0];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic tune(input tune_t mode);
    reg_set_t v;
    case (mode)
      TUNE_UPPER: v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h0000_0000, 32'h0000_FFFF, 32'h0000_FFFF};
      TUNE_LOWER: v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001};
      TUNE_WILD: begin
        for (int k = 0; k < 5; k++) v[k] = $urandom();
        v[5] = $urandom() & 32'h7FFF_FFFF;
        v[6] = $urandom_range(0, 65535);
        v[7] = $urandom_range(1, 65535);
      end
      default: begin
        v[0] = rand_sign($urandom_range(0, 4 << 16));
        v[1] = rand_sign($urandom_range(0, 8 << 16));
        v[2] = rand_sign($urandom_range(0, 'h800));
        v[3] = $urandom_range(1 << 16, 30 << 16);
        v[4] = -$urandom_range(0, 30 << 16);
        v[5] = $urandom_range(0, 1) ? 0 : $urandom_range(0, 'h2000);
        v[6] = $urandom_range(0, 65535);
        v[7] = $urandom_range(1, 65535);
        if (mode == TUNE_HOLD_ALL) v[5] = 32'h7FFF_FFFF;
      end
    endcase
    load_regs(v);
  endtask

  task automatic wait_idle();
    while (reqs_sent != reqs_queued || expected_pwm.size() != 0) @(negedge clk);
  endtask

  // Request driver: hold each request until taken, then pause or load the next
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        {target_velocity, measured_velocity, elapsed_us} <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        send_gap <= gaps_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      recv_wait <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 99) < 25) begin
      out_ready <= 1'b0;
      recv_wait <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each taken request, check each taken result
  always @(posedge clk) begin : watch
    pwm_res_t want, got;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      pid_predict(vel_req_t'({target_velocity, measured_velocity, elapsed_us}), want);
      expected_pwm.push_back(want);
      reqs_sent++;
    end
    if (!rst && out_valid && out_ready) begin
      got = '{compare_value, drive_command, error_value, held, zero_interval};
      results_seen++;
      if (expected_pwm.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: cmp %0d cmd %h err %h held %b zero %b",
                   got.compare, got.command, got.err_v, got.held, got.zero_int);
      end else begin
        want = expected_pwm.pop_front();
        if (got.compare !== want.compare || got.command !== want.command ||
            got.err_v !== want.err_v || got.held !== want.held ||
            got.zero_int !== want.zero_int) begin
          fail_count++;
          if (fail_count <= 10) begin
            $write("mismatch at result %0d (got/expected): cmp %0d/%0d cmd %h/%h ",
                   results_seen, got.compare, want.compare, got.command, want.command);
            $display("err %h/%h held %b/%b zero %b/%b",
                     got.err_v, want.err_v, got.held, want.held,
                     got.zero_int, want.zero_int);
          end
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_pwm.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    reg_set_t regs;
    tune_t    phase_mode [9];
    int       phase_len [9];
    phase_mode = '{TUNE_MODERATE, TUNE_UPPER, TUNE_MODERATE, TUNE_LOWER, TUNE_WILD,
                   TUNE_MODERATE, TUNE_HOLD_ALL, TUNE_WILD, TUNE_MODERATE};
    phase_len  = '{140, 40, 140, 40, 140, 140, 30, 140, 140};

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset registers: field extremes, error and integral saturation, clamps, negative duty
    add_req(32'h0000_0000, 32'h0000_0000, 20'd0);
    add_req(32'h7FFF_FFFF, 32'h8000_0000, 20'hF_FFFF);
    add_req(32'h8000_0000, 32'h7FFF_FFFF, 20'd1);
    add_req(32'h0000_8000, 32'h0000_0000, 20'd1000);
    add_req(32'h0001_0000, 32'h0000_0000, 20'd1000);
    add_req(32'h0001_0001, 32'h0000_0000, 20'd1000);
    add_req(32'hFFFF_0000, 32'h0000_0000, 20'd500);
    add_req(32'hFFFE_0000, 32'h0000_0000, 20'd500);
    add_req(32'h0000_0005, 32'h0000_0005, 20'd0);
    add_req(32'h8000_0000, 32'h8000_0000, 20'd7);
    add_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'hF_FFFF);
    add_req(32'h5555_5555, 32'hAAAA_AAAA, 20'h5_A5A5);
    add_req(32'hAAAA_AAAA, 32'h5555_5555, 20'hA_5A5A);
    wait_idle();

    // All three gains on with a small deadband: deadband edges, derivative, saturation swing
    regs = '{32'h0002_0000, 32'h0001_0000, 32'h0000_0400, 32'h0003_0000,
             32'hFFFD_0000, 32'h0000_0800, 32'h0000_C000, 32'd4000};
    load_regs(regs);
    add_req(32'h0003_0000, 32'h0001_0000, 20'd1000);
    add_req(32'h0001_0400, 32'h0001_0000, 20'd1000);
    add_req(32'h0001_0800, 32'h0001_0000, 20'd1000);
    add_req(32'h0001_0801, 32'h0001_0000, 20'd1000);
    add_req(32'h0001_0000, 32'h0001_0000, 20'd0);
    add_req(32'hFFFC_0000, 32'h0000_0000, 20'd2000);
    add_req(32'h0002_0000, 32'h0002_8000, 20'd1);
    add_req(32'h7FFF_FFFF, 32'h8000_0000, 20'hF_FFFF);
    add_req(32'h8000_0000, 32'h7FFF_FFFF, 20'hF_FFFF);
    add_req(32'h8000_0000, 32'h7FFF_FFFF, 20'hF_FFFF);
    add_req(32'h0000_0000, 32'h0000_0000, 20'd1);
    wait_idle();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 9; ph++) begin
      tune(phase_mode[ph]);
      gaps_on   = (ph != 5);
      stalls_on = (ph != 5);
      for (int n = 0; n < phase_len[ph]; n++) add_random_req();
      // Back-pressure the result side while requests keep coming
      if (ph == 2) hold_reqs++;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Ran %0d velocity requests through %0d register settings, %0d results checked",
             reqs_sent, settings_used, results_seen);
    $display("Deadband holds %0d, zero intervals %0d, clamped sums %0d, failures %0d",
             hold_count, zero_count, clamp_count, fail_count);
    if (fail_count == 0 && expected_pwm.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### pid_velocity_pwm_controller.f
rtl/pvpc_pkg.sv
rtl/pvpc_mul.sv
rtl/pvpc_div.sv
rtl/pid_velocity_pwm_controller.sv
bench/testbench.sv
